// ===== design/hdsm_pkg.sv =====
// Types, constants and helpers shared by the Hall direction and speed meter.
`default_nettype none
package hdsm_pkg;

	localparam int CAPTURE_BITS      = 16;
	localparam int FRACTION_BITS_DEF = 8;
	localparam int CLOCK_W           = 28;
	localparam int TALLY_W           = 16;
	localparam int TOTAL_W           = 32;
	localparam int FREQ_W            = 36;
	localparam int PROD_W            = CLOCK_W + TALLY_W;
	localparam int PHASE_W           = 3;
	localparam int PADDR_W           = 3;
	localparam int PDATA_W           = 32;

	localparam logic [CLOCK_W-1:0] CLOCK_RESET = CLOCK_W'(1000000);
	localparam logic [PHASE_W-1:0] PHASE_NONE  = 3'h7;

	localparam logic CMD_EDGE  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [PADDR_W-3:0] REG_TIMER_CLOCK = '0;

	typedef struct packed {
		logic                    command;
		logic [PHASE_W-1:0]      hall_phase;
		logic [CAPTURE_BITS-1:0] capture_period;
	} hdsm_item_t;

	typedef struct packed {
		logic              rotation_ccw;
		logic              speed_valid;
		logic [FREQ_W-1:0] edge_frequency;
	} hdsm_result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV
	} hdsm_state_t;

	// phase that precedes the given one when turning counter-clockwise
	function automatic logic [PHASE_W-1:0] ccw_pred(input logic [PHASE_W-1:0] phase);
		logic [PHASE_W-1:0] pred;
		case (phase)
			3'd0:    pred = 3'd0;
			3'd1:    pred = 3'd3;
			3'd2:    pred = 3'd6;
			3'd3:    pred = 3'd2;
			3'd4:    pred = 3'd5;
			3'd5:    pred = 3'd1;
			3'd6:    pred = 3'd4;
			default: pred = 3'd0;
		endcase
		return pred;
	endfunction

endpackage
`default_nettype wire

// ===== design/hall_direction_speed_meter_unit.sv =====
// Hall direction and speed meter: top level with sequencer, state and APB register.
// An edge transfer updates direction, edge tally and period total and yields its
// result the cycle after acceptance. A speed query with data forms the product of
// clock rate and tally and loads the restoring divider in ST_MUL, which yields one
// quotient bit per cycle over the 44 + FRACTION_BITS bit numerator; the quotient is
// then registered as the result, and the next item can be taken once the sequencer
// is back in ST_IDLE. A query with no data answers in the cycle after acceptance.
// No item is taken while a query is in the divider. The result register holds one
// result; a new item is taken when it is empty or being emptied in the same cycle.
`default_nettype none
module hall_direction_speed_meter_unit
	import hdsm_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire hdsm_item_t         item,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output hdsm_result_t            result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready
);

	localparam int NUM_W = PROD_W + FRACTION_BITS;

	hdsm_state_t state_q, state_d;

	logic [CLOCK_W-1:0] clk_hz_q;
	logic [PHASE_W-1:0] prev_phase_q;
	logic               dir_q;
	logic [TALLY_W-1:0] tally_q;
	logic [TOTAL_W-1:0] total_q;
	logic               result_valid_q;
	hdsm_result_t       result_q;

	logic               accept;
	logic               is_edge;
	logic               is_query;
	logic               query_empty;
	logic               new_dir;
	logic [TOTAL_W:0]   sum;
	logic               div_start;
	logic               div_done;
	logic [NUM_W-1:0]   quot;
	logic [PROD_W-1:0]  prod;
	logic [FREQ_W-1:0]  freq;
	logic               reg_write;

	// configuration
	assign pready    = 1'b1;
	assign reg_write = psel & penable & pwrite & (paddr[PADDR_W-1:2] == REG_TIMER_CLOCK);
	assign prdata    = (paddr[PADDR_W-1:2] == REG_TIMER_CLOCK) ? PDATA_W'(clk_hz_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= CLOCK_RESET;
		end else if (reg_write) begin
			clk_hz_q <= pwdata[CLOCK_W-1:0];
		end
	end

	// item decode
	assign accept      = item_valid & item_ready;
	assign is_edge     = accept & (item.command == CMD_EDGE);
	assign is_query    = accept & (item.command == CMD_QUERY);
	assign query_empty = (tally_q == '0) || (total_q == '0);
	assign new_dir     = (item.hall_phase != PHASE_NONE) &&
	                     (ccw_pred(item.hall_phase) == prev_phase_q);
	assign sum         = {1'b0, total_q} + (TOTAL_W + 1)'(item.capture_period);

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (is_query && !query_empty) state_d = ST_MUL;
			ST_MUL:  state_d = ST_DIV;
			ST_DIV:  if (div_done) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready = 1'b0;
		div_start  = 1'b0;
		case (state_q)
			ST_IDLE: item_ready = !result_valid_q || result_ready;
			ST_MUL:  div_start  = 1'b1;
			ST_DIV:  item_ready = 1'b0;
			default: item_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// measurement state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_phase_q <= '0;
			dir_q        <= 1'b0;
			tally_q      <= '0;
			total_q      <= '0;
		end else if (is_edge) begin
			prev_phase_q <= item.hall_phase;
			dir_q        <= new_dir;
			if (tally_q != '1) tally_q <= tally_q + 1'b1;
			total_q <= sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
		end else if (div_start) begin
			tally_q <= '0;
			total_q <= '0;
		end
	end

	// rate = clock * tally << FRACTION_BITS / total
	assign prod = clk_hz_q * tally_q;

	hdsm_div #(
		.NUM_W (NUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (NUM_W'(prod) << FRACTION_BITS),
		.denom  (total_q),
		.done   (div_done),
		.quot   (quot)
	);

	assign freq = (quot[NUM_W-1:FREQ_W] != '0) ? '1 : quot[FREQ_W-1:0];

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (is_edge || (is_query && query_empty) ||
		             (state_q == ST_DIV && div_done)) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_edge) begin
			result_q.rotation_ccw   <= new_dir;
			result_q.speed_valid    <= 1'b0;
			result_q.edge_frequency <= '0;
		end else if (is_query && query_empty) begin
			result_q.rotation_ccw   <= dir_q;
			result_q.speed_valid    <= 1'b1;
			result_q.edge_frequency <= '0;
		end else if (state_q == ST_DIV && div_done) begin
			result_q.rotation_ccw   <= dir_q;
			result_q.speed_valid    <= 1'b1;
			result_q.edge_frequency <= freq;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_query_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |=> (tally_q == '0 && total_q == '0))
		else $error("query did not clear tally and total");

	a_div_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_done) |=> (result_valid_q && result_q.speed_valid))
		else $error("divider result not presented");

	a_edge_result: assert property (@(posedge clk) disable iff (!arst_n)
		is_edge |=> (result_valid_q && !result_q.speed_valid &&
		             result_q.edge_frequency == '0))
		else $error("edge transfer gave no edge result");

endmodule
`default_nettype wire

// ===== design/hdsm_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module hdsm_div
	import hdsm_pkg::*;
#(
	parameter int NUM_W = PROD_W + FRACTION_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [NUM_W-1:0]   numer,
	input  wire logic [TOTAL_W-1:0] denom,
	output logic                    done,
	output logic [NUM_W-1:0]        quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [NUM_W-1:0]   acc_q;
	logic [TOTAL_W-1:0] rem_q;
	logic [TOTAL_W-1:0] denom_q;

	logic [TOTAL_W:0]   shifted;
	logic [TOTAL_W+1:0] diff;
	logic               take;

	assign shifted = {rem_q, acc_q[NUM_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, denom_q};
	assign take    = ~diff[TOTAL_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q   <= numer;
			rem_q   <= '0;
			denom_q <= denom;
		end else if (busy_q) begin
			acc_q <= {acc_q[NUM_W-2:0], take};
			rem_q <= take ? diff[TOTAL_W-1:0] : shifted[TOTAL_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = acc_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("divider not busy after start");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while busy");

	a_denom_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> denom_q != '0)
		else $error("divider running on zero divisor");

endmodule
`default_nettype wire
